// File: rtl/core/mcrb_pkg.sv
// Shared constants, codes and types of the multi-client receive ring buffer.
`timescale 1ns / 1ps

package mcrb_pkg;

  localparam int CLIENTS = 3;
  localparam int DEPTH   = 255;
  localparam int SLOTS   = DEPTH + 1;
  localparam int PTR_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CLI_W   = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int ADDR_W  = $clog2(CLIENTS * SLOTS);
  localparam int STORE_N = CLIENTS * SLOTS;

  localparam logic [7:0] RT_LIMIT = 8'h7F;

  typedef enum logic [1:0] {
    OP_RECEIVE = 2'd0,
    OP_READ    = 2'd1,
    OP_FLUSH   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_CODE_RESET       = 2'd0,
    REG_CODE_STATUS      = 2'd1,
    REG_CODE_CYCLE_START = 2'd2,
    REG_CODE_FEED_HOLD   = 2'd3
  } reg_e;

  typedef struct packed {
    logic [7:0] reset_code;
    logic [7:0] status_code;
    logic [7:0] cycle_start_code;
    logic [7:0] feed_hold_code;
  } codes_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic       read_valid;
    logic [7:0] free_space;
    logic       realtime_valid;
    logic [7:0] realtime_code;
    logic       byte_stored;
    logic       byte_dropped;
  } res_t;

endpackage

// File: rtl/core/mcrb_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module mcrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/mcrb_ring_ctrl.sv
// Per-client ring pointers, byte classification and free-space calculation.
`timescale 1ns / 1ps

module mcrb_ring_ctrl
  import mcrb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [1:0] operation_i,
  input  logic [1:0] client_i,
  input  logic       flush_all_i,
  input  logic [7:0] rx_byte_i,
  input  codes_t     codes_i,
  output mem_req_t   mem_req_o,
  output res_t       res_o
);

  logic [PTR_W-1:0] wp_q [CLIENTS];
  logic [PTR_W-1:0] wp_d [CLIENTS];
  logic [PTR_W-1:0] rp_q [CLIENTS];
  logic [PTR_W-1:0] rp_d [CLIENTS];

  logic              ok;
  logic [CLI_W-1:0]  idx;
  logic [PTR_W-1:0]  cur_w;
  logic [PTR_W-1:0]  cur_r;
  logic [PTR_W-1:0]  next_w;
  logic [PTR_W-1:0]  next_r;
  logic [PTR_W-1:0]  new_w;
  logic [PTR_W-1:0]  new_r;
  logic [PTR_W:0]    occ;
  logic              is_rt;
  logic [ADDR_W-1:0] base;

  always_comb begin
    ok     = (32'(client_i) < CLIENTS);
    idx    = CLI_W'(client_i);
    cur_w  = ok ? wp_q[idx] : '0;
    cur_r  = ok ? rp_q[idx] : '0;
    next_w = (cur_w == PTR_W'(DEPTH)) ? '0 : cur_w + PTR_W'(1);
    next_r = (cur_r == PTR_W'(DEPTH)) ? '0 : cur_r + PTR_W'(1);
    base   = ADDR_W'(ADDR_W'(idx) * ADDR_W'(SLOTS));
    is_rt  = (rx_byte_i == codes_i.reset_code) || (rx_byte_i == codes_i.status_code) ||
             (rx_byte_i == codes_i.cycle_start_code) ||
             (rx_byte_i == codes_i.feed_hold_code) || (rx_byte_i > RT_LIMIT);

    wp_d = wp_q;
    rp_d = rp_q;
    res_o = '0;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = base + ADDR_W'(cur_w);
    mem_req_o.wdata = rx_byte_i;
    mem_req_o.re    = 1'b0;
    mem_req_o.raddr = base + ADDR_W'(cur_r);

    case (operation_i)
      OP_RECEIVE: begin
        if (is_rt) begin
          res_o.realtime_valid = 1'b1;
          res_o.realtime_code  = rx_byte_i;
        end else if (ok && (next_w != cur_r)) begin
          mem_req_o.we      = fire_i;
          wp_d[idx]         = next_w;
          res_o.byte_stored = 1'b1;
        end else begin
          res_o.byte_dropped = 1'b1;
        end
      end
      OP_READ: begin
        if (ok && (cur_w != cur_r)) begin
          mem_req_o.re     = fire_i;
          rp_d[idx]        = next_r;
          res_o.read_valid = 1'b1;
        end
      end
      OP_FLUSH: begin
        for (int k = 0; k < CLIENTS; k++) begin
          if (flush_all_i || (32'(client_i) == k)) begin
            rp_d[k] = wp_q[k];
          end
        end
      end
      default: begin
      end
    endcase

    // Free space is taken from the pointers as they stand after this word.
    new_w = ok ? wp_d[idx] : '0;
    new_r = ok ? rp_d[idx] : '0;
    occ   = (PTR_W+1)'(new_w) - (PTR_W+1)'(new_r);
    if (new_w < new_r) begin
      occ = occ + (PTR_W+1)'(SLOTS);
    end
    res_o.free_space = ok ? 8'((PTR_W+1)'(DEPTH) - occ) : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CLIENTS; k++) begin
        wp_q[k] <= '0;
        rp_q[k] <= '0;
      end
    end else if (fire_i) begin
      wp_q <= wp_d;
      rp_q <= rp_d;
    end
  end

endmodule

// File: rtl/core/multi_client_rx_ring_buffer.sv
// Top level of the multi-client receive ring buffer with its stream ports.
`timescale 1ns / 1ps

// Three client rings of up to 255 bytes each share one 768-byte RAM. Each
// input word receives, reads or flushes, and gives exactly one result word in
// the cycle after it is accepted. A new word is taken in every cycle as long as
// the result register is empty or being drained in that same cycle; the ring
// pointers are updated at the accept edge, so back-to-back words on one ring
// see each other's effects. Read bytes come from the RAM read register. Bytes
// that match a configured realtime code, or lie above 0x7F, bypass the rings
// and come out on the realtime fields. The RAM needs no clearing pass.
module multi_client_rx_ring_buffer
  import mcrb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // rx_byte [7:0]
  input  logic [7:0]  s_axis_tdata,
  // operation [1:0], client [3:2], flush_all [4]
  input  logic [4:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_byte [7:0], read_valid [8], free_space [16:9], realtime_valid [17],
  // realtime_code [25:18], byte_stored [26], byte_dropped [27], zero [31:28]
  output logic [31:0] m_axis_tdata
);

  codes_t   codes_q;
  mem_req_t mem_req;
  res_t     res;
  res_t     res_q;
  logic     out_valid_q;
  logic     fire;
  logic [7:0] ram_rdata;
  logic [7:0] read_byte;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q.reset_code       <= 8'd24;
      codes_q.status_code      <= 8'd63;
      codes_q.cycle_start_code <= 8'd126;
      codes_q.feed_hold_code   <= 8'd33;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_CODE_RESET:       codes_q.reset_code       <= cfg_wdata_i;
        REG_CODE_STATUS:      codes_q.status_code      <= cfg_wdata_i;
        REG_CODE_CYCLE_START: codes_q.cycle_start_code <= cfg_wdata_i;
        REG_CODE_FEED_HOLD:   codes_q.feed_hold_code   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  mcrb_ring_ctrl u_ring_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .operation_i (s_axis_tuser[1:0]),
    .client_i    (s_axis_tuser[3:2]),
    .flush_all_i (s_axis_tuser[4]),
    .rx_byte_i   (s_axis_tdata),
    .codes_i     (codes_q),
    .mem_req_o   (mem_req),
    .res_o       (res)
  );

  mcrb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_N)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  // The RAM read register only loads on an accepted read, so it holds while stalled.
  assign read_byte = res_q.read_valid ? ram_rdata : 8'd0;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, res_q.byte_dropped, res_q.byte_stored, res_q.realtime_code,
                          res_q.realtime_valid, res_q.free_space, res_q.read_valid,
                          read_byte};

  a_store_xor_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.byte_stored && res_q.byte_dropped))
    else $error("byte both stored and dropped");

  a_rt_not_stored : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.realtime_valid) |-> !res_q.byte_stored && !res_q.byte_dropped)
    else $error("realtime byte reached the ring logic");

  a_pop_frees_space : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.read_valid) |-> (res_q.free_space != 8'd0))
    else $error("successful read left no free space");

  a_one_ram_access : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> !mem_req.re)
    else $error("RAM written and read by the same word");

endmodule

// File: bench/tb_multi_client_rx_ring_buffer.sv
// Self-checking testbench for the multi-client receive ring buffer.
`timescale 1ns / 1ps

module tb_multi_client_rx_ring_buffer;
  import mcrb_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 200_000;

  // Result word as it appears on m_axis_tdata, highest field first.
  typedef struct packed {
    logic [3:0] pad;
    logic       dropped;
    logic       stored;
    logic [7:0] rt_code;
    logic       rt_valid;
    logic [7:0] room;
    logic       rd_valid;
    logic [7:0] rd_byte;
  } rx_result_t;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] cli;
    logic       flush_every;
    logic [7:0] data;
    logic       typed;
    logic [7:0] rd_byte;
    logic       rd_valid;
    logic [7:0] room;
    logic       rt_valid;
    logic [7:0] rt_code;
    logic       stored;
    logic       dropped;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [7:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // rx_byte [7:0]
  logic [4:0]  s_axis_tuser;   // operation [1:0], client [3:2], flush_all [4]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // read_byte [7:0], read_valid [8], free_space [16:9], realtime_valid [17],
  // realtime_code [25:18], byte_stored [26], byte_dropped [27], zero [31:28]
  logic [31:0] m_axis_tdata;

  // Shadow copy of the rings and the realtime codes.
  int         ring_head [CLIENTS];
  int         ring_tail [CLIENTS];
  logic [7:0] ring_data [CLIENTS][SLOTS];
  logic [7:0] rt_codes  [4];

  rx_result_t expected_results[$];
  rx_result_t got_result;
  rx_result_t want_result;
  rx_result_t typed_result;
  bit         word_typed;
  bit         quiet;
  int         errors;
  int         cycles;
  dir_row_t   script [25];

  multi_client_rx_ring_buffer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] ring_room(input int c);
    int h;
    int t;
    h = ring_head[c];
    t = ring_tail[c];
    return (h >= t) ? 8'(DEPTH - (h - t)) : 8'(t - h - 1);
  endfunction

  // Applies one input word to the shadow rings and returns its result word.
  function automatic rx_result_t apply_word(input logic [1:0] op, input logic [1:0] cli,
                                            input logic every, input logic [7:0] b);
    rx_result_t r;
    int         nxt;
    bit         known;
    bit         rt;
    r     = '0;
    known = cli < CLIENTS;
    case (op)
      OP_RECEIVE: begin
        rt = b == rt_codes[REG_CODE_RESET] || b == rt_codes[REG_CODE_STATUS] ||
             b == rt_codes[REG_CODE_CYCLE_START] || b == rt_codes[REG_CODE_FEED_HOLD] ||
             b > RT_LIMIT;
        if (rt) begin
          r.rt_valid = 1'b1;
          r.rt_code  = b;
        end else if (!known) begin
          r.dropped = 1'b1;
        end else begin
          nxt = (ring_head[cli] + 1) % SLOTS;
          if (nxt == ring_tail[cli]) begin
            r.dropped = 1'b1;
          end else begin
            ring_data[cli][ring_head[cli]] = b;
            ring_head[cli] = nxt;
            r.stored = 1'b1;
          end
        end
      end
      OP_READ: begin
        if (known && ring_head[cli] != ring_tail[cli]) begin
          r.rd_byte      = ring_data[cli][ring_tail[cli]];
          r.rd_valid     = 1'b1;
          ring_tail[cli] = (ring_tail[cli] + 1) % SLOTS;
        end
      end
      OP_FLUSH: begin
        for (int k = 0; k < CLIENTS; k++)
          if (every || k == cli) ring_tail[k] = ring_head[k];
      end
      default: ;
    endcase
    if (known) r.room = ring_room(cli);
    return r;
  endfunction

  function automatic string show(input rx_result_t r);
    return $sformatf("read %b/%h free %0d realtime %b/%h stored %b dropped %b pad %h",
                     r.rd_valid, r.rd_byte, r.room, r.rt_valid, r.rt_code, r.stored,
                     r.dropped, r.pad);
  endfunction

  task automatic report(input string what, input string want_s, input string got_s);
    errors++;
    if (errors <= 10) $display("mismatch (%s): expected %s, got %s", what, want_s, got_s);
  endtask

  // Checks result words and predicts accepted input words at each rising edge.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_multi_client_rx_ring_buffer: done, errors");
      $finish;
    end else if (rst_ni) begin
      if (cfg_we_i) rt_codes[cfg_index_i] = cfg_wdata_i;
      // A result leaves no earlier than the cycle after its word is taken, so check before predicting.
      if (m_axis_tvalid && m_axis_tready) begin
        got_result = m_axis_tdata;
        if (expected_results.size() == 0) begin
          report("unexpected word", "nothing", show(got_result));
        end else begin
          want_result = expected_results.pop_front();
          if (got_result !== want_result) report("result", show(want_result), show(got_result));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want_result = apply_word(s_axis_tuser[1:0], s_axis_tuser[3:2], s_axis_tuser[4],
                                 s_axis_tdata);
        expected_results.push_back(word_typed ? typed_result : want_result);
      end
    end
  end

  // Result side: stalls at random before taking each word, but never while quiet.
  initial begin : drain
    int stall;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!(m_axis_tvalid && m_axis_tready)) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // Returns at the falling edge after the word is taken, with tvalid still high.
  task automatic send_word(input logic [1:0] op, input logic [1:0] cli, input logic every,
                           input logic [7:0] b, input bit typed, input rx_result_t want);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    word_typed    = typed;
    typed_result  = want;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= {every, cli, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_mixed(input int rx_pct);
    int         pick;
    logic [1:0] op;
    logic [1:0] cli;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < rx_pct) op = OP_RECEIVE;
    else if (pick < 96) op = OP_READ;
    else if (pick < 98) op = OP_FLUSH;
    else op = OP_UNUSED;
    cli  = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    pick = $urandom_range(0, 99);
    if (pick < 12) b = rt_codes[$urandom_range(0, 3)];
    else if (pick < 25) b = 8'($urandom_range(128, 255));
    else b = 8'($urandom_range(0, 127));
    send_word(op, cli, 1'($urandom_range(0, 1)), b, 1'b0, '0);
  endtask

  // Waits until every result is back, then writes all four codes.
  task automatic write_codes(input logic [7:0] rst_c, input logic [7:0] stat_c,
                             input logic [7:0] start_c, input logic [7:0] hold_c);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_CODE_RESET;
    cfg_wdata_i <= rst_c;
    @(negedge clk_i);
    cfg_index_i <= REG_CODE_STATUS;
    cfg_wdata_i <= stat_c;
    @(negedge clk_i);
    cfg_index_i <= REG_CODE_CYCLE_START;
    cfg_wdata_i <= start_c;
    @(negedge clk_i);
    cfg_index_i <= REG_CODE_FEED_HOLD;
    cfg_wdata_i <= hold_c;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    int fill_client;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= REG_CODE_RESET;
    cfg_wdata_i   <= 8'h00;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tuser  <= '0;
    quiet         = 1'b0;
    errors        = 0;
    cycles        = 0;
    word_typed    = 1'b0;
    typed_result  = '0;
    for (int c = 0; c < CLIENTS; c++) begin
      ring_head[c] = 0;
      ring_tail[c] = 0;
    end
    rt_codes[REG_CODE_RESET]       = 8'd24;
    rt_codes[REG_CODE_STATUS]      = 8'd63;
    rt_codes[REG_CODE_CYCLE_START] = 8'd126;
    rt_codes[REG_CODE_FEED_HOLD]   = 8'd33;

    // op, client, flush_all, byte | typed, read byte, read valid, free,
    // realtime valid, realtime code, stored, dropped
    script = '{
      '{OP_RECEIVE, 2'd0, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 8'd0,   1'b0, 8'h00, 1'b0, 1'b0},
      '{OP_READ,    2'd0, 1'b0, 8'h00, 1'b1, 8'h00, 1'b1, 8'd255, 1'b0, 8'h00, 1'b0, 1'b0},
      '{OP_RECEIVE, 2'd0, 1'b0, 8'h00, 1'b1, 8'h00, 1'b0, 8'd254, 1'b0, 8'h00, 1'b1, 1'b0},
      '{OP_RECEIVE, 2'd1, 1'b0, 8'hFF, 1'b1, 8'h00, 1'b0, 8'd255, 1'b1, 8'hFF, 1'b0, 1'b0},
      '{OP_RECEIVE, 2'd2, 1'b1, 8'h80, 1'b1, 8'h00, 1'b0, 8'd255, 1'b1, 8'h80, 1'b0, 1'b0},
      '{OP_RECEIVE, 2'd2, 1'b0, 8'h7F, 1'b1, 8'h00, 1'b0, 8'd254, 1'b0, 8'h00, 1'b1, 1'b0},
      '{OP_RECEIVE, 2'd0, 1'b0, 8'h18, 1'b1, 8'h00, 1'b0, 8'd254, 1'b1, 8'h18, 1'b0, 1'b0},
      '{OP_RECEIVE, 2'd0, 1'b1, 8'h3F, 1'b1, 8'h00, 1'b0, 8'd254, 1'b1, 8'h3F, 1'b0, 1'b0},
      '{OP_RECEIVE, 2'd1, 1'b0, 8'h7E, 1'b1, 8'h00, 1'b0, 8'd255, 1'b1, 8'h7E, 1'b0, 1'b0},
      '{OP_RECEIVE, 2'd2, 1'b0, 8'h21, 1'b1, 8'h00, 1'b0, 8'd254, 1'b1, 8'h21, 1'b0, 1'b0},
      '{OP_READ,    2'd0, 1'b1, 8'hAA, 1'b1, 8'h00, 1'b1, 8'd255, 1'b0, 8'h00, 1'b0, 1'b0},
      '{OP_READ,    2'd2, 1'b0, 8'h55, 1'b1, 8'h7F, 1'b1, 8'd255, 1'b0, 8'h00, 1'b0, 1'b0},
      '{OP_RECEIVE, 2'd3, 1'b0, 8'h55, 1'b1, 8'h00, 1'b0, 8'd0,   1'b0, 8'h00, 1'b0, 1'b1},
      '{OP_RECEIVE, 2'd3, 1'b1, 8'h90, 1'b1, 8'h00, 1'b0, 8'd0,   1'b1, 8'h90, 1'b0, 1'b0},
      '{OP_READ,    2'd3, 1'b0, 8'h00, 1'b1, 8'h00, 1'b0, 8'd0,   1'b0, 8'h00, 1'b0, 1'b0},
      '{OP_FLUSH,   2'd3, 1'b0, 8'hFF, 1'b1, 8'h00, 1'b0, 8'd0,   1'b0, 8'h00, 1'b0, 1'b0},
      '{OP_UNUSED,  2'd0, 1'b0, 8'h00, 1'b1, 8'h00, 1'b0, 8'd255, 1'b0, 8'h00, 1'b0, 1'b0},
      '{OP_RECEIVE, 2'd1, 1'b0, 8'h41, 1'b1, 8'h00, 1'b0, 8'd254, 1'b0, 8'h00, 1'b1, 1'b0},
      '{OP_RECEIVE, 2'd2, 1'b0, 8'h42, 1'b1, 8'h00, 1'b0, 8'd254, 1'b0, 8'h00, 1'b1, 1'b0},
      '{OP_FLUSH,   2'd1, 1'b0, 8'h00, 1'b1, 8'h00, 1'b0, 8'd255, 1'b0, 8'h00, 1'b0, 1'b0},
      '{OP_READ,    2'd1, 1'b0, 8'h00, 1'b1, 8'h00, 1'b0, 8'd255, 1'b0, 8'h00, 1'b0, 1'b0},
      '{OP_FLUSH,   2'd3, 1'b1, 8'h00, 1'b1, 8'h00, 1'b0, 8'd0,   1'b0, 8'h00, 1'b0, 1'b0},
      '{OP_READ,    2'd2, 1'b0, 8'h00, 1'b1, 8'h00, 1'b0, 8'd255, 1'b0, 8'h00, 1'b0, 1'b0},
      '{OP_UNUSED,  2'd3, 1'b1, 8'hFF, 1'b1, 8'h00, 1'b0, 8'd0,   1'b0, 8'h00, 1'b0, 1'b0},
      '{OP_RECEIVE, 2'd0, 1'b0, 8'h01, 1'b0, 8'h00, 1'b0, 8'd0,   1'b0, 8'h00, 1'b0, 1'b0}
    };

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < $size(script); i++)
      send_word(script[i].op, script[i].cli, script[i].flush_every, script[i].data,
                script[i].typed,
                '{4'h0, script[i].dropped, script[i].stored, script[i].rt_code,
                  script[i].rt_valid, script[i].room, script[i].rd_valid, script[i].rd_byte});

    // Stream bytes of 0x00 to 0x7F into one ring until it is full and starts dropping.
    quiet       = 1'b1;
    fill_client = $urandom_range(0, CLIENTS - 1);
    repeat (270)
      send_word(OP_RECEIVE, 2'(fill_client), 1'($urandom_range(0, 1)),
                8'($urandom_range(0, 127)), 1'b0, '0);
    quiet = 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1: write_codes(8'h00, 8'hFF, 8'h7F, 8'h00);
        2: write_codes(8'($urandom_range(0, 127)), 8'($urandom_range(0, 127)),
                       8'($urandom_range(0, 127)), 8'($urandom_range(0, 127)));
        3: write_codes(8'hFF, 8'h01, 8'h80, 8'h7E);
        default: ;
      endcase
      quiet = (ph == 2);
      repeat (85) send_mixed(ph == 1 ? 45 : (ph == 2 ? 85 : 65));
    end

    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb_multi_client_rx_ring_buffer: done, clean");
    end else begin
      $display("tb_multi_client_rx_ring_buffer: done, errors");
    end
    $finish;
  end

endmodule
